[hdl/fcm_pkg.sv]
// Shared constants and types of the circular-history MAC FIR filter.
`timescale 1ns / 1ps

package fcm_pkg;

  // Default history depth; the top level may override it
  localparam int HISTORY_DEPTH_DEF = 64;

  // Coefficient store geometry
  localparam int COEF_DEPTH = 64;
  localparam int COEF_AW    = 6;

  // Field and datapath widths
  localparam int SAMPLE_W  = 16;
  localparam int TAP_W     = 7;
  localparam int ACC_W     = 32;
  localparam int FRAC_BITS = 15;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 1'b1;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_LOAD   = 1'b1;

  // Filter modes
  localparam logic MODE_DIRECT    = 1'b0;
  localparam logic MODE_SYMMETRIC = 1'b1;

  // Register reset values
  localparam logic             MODE_RST      = MODE_SYMMETRIC;
  localparam logic [TAP_W-1:0] TAP_COUNT_RST = 7'd63;

  // Per-cycle control from the sequencer to the MAC datapath
  typedef struct packed {
    logic clear;   // zero the accumulator
    logic vld;     // an operand read was issued this cycle
    logic first;   // first sample of a symmetric pair
    logic second;  // second sample of a symmetric pair
  } mac_ctl_t;

endpackage

[hdl/fir_filter_circular_mac_core.sv]
// Flow: a sample is accepted only while the sequencer is idle; it then walks its taps in
//   S_RUN (none for zero taps), drains the MAC pipeline in S_DRAIN and waits in S_DONE
//   until the output register is free; a stalled output holds the sequencer in S_DONE.
// Sharing: no new sample or load is taken until the last sample is through, set by the single
//   history read port and the one shared multiplier; a coefficient load gives no result.
// Reset: synchronous, active low; mode symmetric, tap count 63, history and coefficients
//   read as zero through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

module fir_filter_circular_mac_core #(
  parameter int HISTORY_DEPTH = fcm_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0] in_sample,
  input  logic [fcm_pkg::COEF_AW-1:0]    in_coef_index,
  input  logic signed [fcm_pkg::SAMPLE_W-1:0] in_coef_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [fcm_pkg::SAMPLE_W-1:0] out_filtered,
  input  logic                           cfg_we,
  input  logic [fcm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int HAW = $clog2(HISTORY_DEPTH);
  localparam int SW  = fcm_pkg::SAMPLE_W;

  logic                      mode_r, mode_nxt;
  logic [fcm_pkg::TAP_W-1:0] tap_count_r, tap_count_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [SW-1:0]             out_filtered_r;

  logic [HISTORY_DEPTH-1:0]      hv_r;
  logic [fcm_pkg::COEF_DEPTH-1:0] cv_r;
  logic                          hvb_r;
  logic                          cvb_r;

  logic                          in_fire;
  logic                          hist_we;
  logic                          coef_we;
  logic [HAW-1:0]                hist_waddr;
  logic [HAW-1:0]                hist_raddr;
  logic [fcm_pkg::COEF_AW-1:0]   coef_raddr;
  logic [SW-1:0]                 hist_rdata;
  logic [SW-1:0]                 coef_rdata;
  fcm_pkg::mac_ctl_t             ctl;
  logic                          mac_busy;
  logic [fcm_pkg::ACC_W-1:0]     acc;
  logic                          out_free;
  logic                          out_load;

  assign in_fire  = in_valid && in_ready;
  assign hist_we  = in_fire && (in_kind == fcm_pkg::KIND_SAMPLE);
  assign coef_we  = in_fire && (in_kind == fcm_pkg::KIND_LOAD);
  assign out_free = !out_valid_r || out_ready;

  // Configuration register writes
  always_comb begin
    mode_nxt      = mode_r;
    tap_count_nxt = tap_count_r;
    if (cfg_we) begin
      case (cfg_index)
        fcm_pkg::REG_MODE:      mode_nxt      = cfg_wdata[0];
        fcm_pkg::REG_TAP_COUNT: tap_count_nxt = cfg_wdata[fcm_pkg::TAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= fcm_pkg::MODE_RST;
      tap_count_r <= fcm_pkg::TAP_COUNT_RST;
    end else begin
      mode_r      <= mode_nxt;
      tap_count_r <= tap_count_nxt;
    end
  end

  // Valid bits: mark written entries, clear all at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= '0;
      cv_r <= '0;
    end else begin
      if (hist_we) begin
        hv_r[hist_waddr] <= 1'b1;
      end
      if (coef_we) begin
        cv_r[in_coef_index] <= 1'b1;
      end
    end
  end

  // Read valid bits alongside the RAM read data
  always_ff @(posedge clk) begin
    hvb_r <= hv_r[hist_raddr];
    cvb_r <= cv_r[coef_raddr];
  end

  fcm_ram #(
    .WIDTH (SW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (in_sample),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  fcm_ram #(
    .WIDTH (SW),
    .DEPTH (fcm_pkg::COEF_DEPTH)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (in_coef_index),
    .wdata (in_coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  fcm_seq #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_kind    (in_kind),
    .mode       (mode_r),
    .tap_count  (tap_count_r),
    .mac_busy   (mac_busy),
    .out_free   (out_free),
    .in_ready   (in_ready),
    .hist_waddr (hist_waddr),
    .hist_raddr (hist_raddr),
    .coef_raddr (coef_raddr),
    .ctl        (ctl),
    .out_load   (out_load)
  );

  fcm_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .hist_rdata (hist_rdata),
    .hist_vld   (hvb_r),
    .coef_rdata (coef_rdata),
    .coef_vld   (cvb_r),
    .busy       (mac_busy),
    .acc        (acc)
  );

  // Output register: load the scaled sum, drop valid once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered_r <= acc[fcm_pkg::FRAC_BITS +: SW];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = signed'(out_filtered_r);

  // The datapath is empty whenever a new transaction can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !mac_busy)
    else $error("MAC pipeline busy while sequencer idle");

  // A sample transaction always starts a filter pass
  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == fcm_pkg::KIND_SAMPLE) |=> !in_ready)
    else $error("sample accepted without starting a filter pass");

  // A coefficient load does not stall the input: it is ready again in the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind == fcm_pkg::KIND_LOAD) |=> in_ready)
    else $error("coefficient load stalled the input");

  // A result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending transaction");

endmodule

[hdl/fcm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module fcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/fcm_seq.sv]
// Sequencer: history pointers, tap counter and per-cycle MAC control.
`timescale 1ns / 1ps

module fcm_seq #(
  parameter int HISTORY_DEPTH = fcm_pkg::HISTORY_DEPTH_DEF,
  localparam int HAW = $clog2(HISTORY_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_kind,
  input  logic                        mode,
  input  logic [fcm_pkg::TAP_W-1:0]   tap_count,
  input  logic                        mac_busy,
  input  logic                        out_free,
  output logic                        in_ready,
  output logic [HAW-1:0]              hist_waddr,
  output logic [HAW-1:0]              hist_raddr,
  output logic [fcm_pkg::COEF_AW-1:0] coef_raddr,
  output fcm_pkg::mac_ctl_t           ctl,
  output logic                        out_load
);

  localparam int PW = HAW + 2;
  localparam int MAX_TAPS = (HISTORY_DEPTH < fcm_pkg::COEF_DEPTH) ?
                            HISTORY_DEPTH : fcm_pkg::COEF_DEPTH;
  localparam logic [HAW-1:0] LAST_POS = HAW'(HISTORY_DEPTH - 1);
  localparam logic [fcm_pkg::TAP_W-1:0] TAP_MAX = fcm_pkg::TAP_W'(MAX_TAPS);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [HAW-1:0]            wp_r, wp_nxt;
  logic [HAW-1:0]            new_ptr_r, new_ptr_nxt;
  logic [HAW-1:0]            old_ptr_r, old_ptr_nxt;
  logic [fcm_pkg::TAP_W-1:0] k_r, k_nxt;
  logic [fcm_pkg::TAP_W-1:0] taps_r, taps_nxt;
  logic [fcm_pkg::TAP_W-1:0] mid_r, mid_nxt;
  logic                      sym_r, sym_nxt;
  logic                      phase_r, phase_nxt;

  logic [HAW-1:0]            pos;
  logic [fcm_pkg::TAP_W-1:0] taps_sat;
  logic [fcm_pkg::TAP_W-1:0] mid_calc;
  logic [PW-1:0]             old_sum;
  logic [HAW-1:0]            old_start;
  logic                      sample_fire;
  logic                      is_single;
  logic                      is_last;
  logic                      running;
  logic [HAW-1:0]            new_dec;
  logic [HAW-1:0]            old_inc;

  // Next write position and window geometry for a new sample
  always_comb begin
    pos       = (wp_r == LAST_POS) ? '0 : wp_r + HAW'(1);
    taps_sat  = (tap_count > TAP_MAX) ? TAP_MAX : tap_count;
    mid_calc  = (taps_sat - fcm_pkg::TAP_W'(1)) >> 1;
    old_sum   = PW'(pos) + PW'(HISTORY_DEPTH) + PW'(1) - PW'(taps_sat);
    old_start = (old_sum >= PW'(HISTORY_DEPTH)) ? HAW'(old_sum - PW'(HISTORY_DEPTH))
                                                 : HAW'(old_sum);
  end

  assign in_ready    = (state_r == S_IDLE);
  assign sample_fire = in_valid && in_ready && (in_kind == fcm_pkg::KIND_SAMPLE);
  assign hist_waddr  = pos;
  assign running     = (state_r == S_RUN);

  // Classify the current tap step
  always_comb begin
    is_single = !sym_r || (k_r == mid_r);
    is_last   = sym_r ? (k_r == mid_r) : (k_r == taps_r - fcm_pkg::TAP_W'(1));
    new_dec   = (new_ptr_r == '0) ? LAST_POS : new_ptr_r - HAW'(1);
    old_inc   = (old_ptr_r == LAST_POS) ? '0 : old_ptr_r + HAW'(1);
  end

  // Read addresses and MAC control for this cycle
  always_comb begin
    hist_raddr = (!is_single && phase_r) ? old_ptr_r : new_ptr_r;
    coef_raddr = k_r[fcm_pkg::COEF_AW-1:0];
    ctl.clear  = sample_fire;
    ctl.vld    = running;
    ctl.first  = running && !is_single && !phase_r;
    ctl.second = running && !is_single && phase_r;
    out_load   = (state_r == S_DONE) && out_free;
  end

  // Sequencer next state
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    new_ptr_nxt = new_ptr_r;
    old_ptr_nxt = old_ptr_r;
    k_nxt       = k_r;
    taps_nxt    = taps_r;
    mid_nxt     = mid_r;
    sym_nxt     = sym_r;
    phase_nxt   = phase_r;
    case (state_r)
      S_IDLE: begin
        if (sample_fire) begin
          wp_nxt      = pos;
          new_ptr_nxt = pos;
          old_ptr_nxt = old_start;
          k_nxt       = '0;
          taps_nxt    = taps_sat;
          mid_nxt     = mid_calc;
          sym_nxt     = (mode == fcm_pkg::MODE_SYMMETRIC);
          phase_nxt   = 1'b0;
          state_nxt   = (taps_sat == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if (is_single) begin
          k_nxt       = k_r + fcm_pkg::TAP_W'(1);
          new_ptr_nxt = new_dec;
          if (is_last) begin
            state_nxt = S_DRAIN;
          end
        end else if (!phase_r) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt   = 1'b0;
          k_nxt       = k_r + fcm_pkg::TAP_W'(1);
          new_ptr_nxt = new_dec;
          old_ptr_nxt = old_inc;
        end
      end
      S_DRAIN: begin
        if (!mac_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      phase_r <= phase_nxt;
    end
  end

  // Walk registers, loaded at the start of each sample and stepped during the walk
  always_ff @(posedge clk) begin
    new_ptr_r <= new_ptr_nxt;
    old_ptr_r <= old_ptr_nxt;
    k_r       <= k_nxt;
    taps_r    <= taps_nxt;
    mid_r     <= mid_nxt;
    sym_r     <= sym_nxt;
  end

endmodule

[hdl/fcm_mac.sv]
// Shared pre-add, multiply and accumulate datapath.
`timescale 1ns / 1ps

module fcm_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fcm_pkg::mac_ctl_t            ctl,
  input  logic [fcm_pkg::SAMPLE_W-1:0] hist_rdata,
  input  logic                         hist_vld,
  input  logic [fcm_pkg::SAMPLE_W-1:0] coef_rdata,
  input  logic                         coef_vld,
  output logic                         busy,
  output logic [fcm_pkg::ACC_W-1:0]    acc
);

  localparam int SW = fcm_pkg::SAMPLE_W;
  localparam int OW = SW + 1;
  localparam int PW = SW + OW;

  fcm_pkg::mac_ctl_t b_ctl_r;
  logic              c_vld_r;

  logic signed [SW-1:0]          x;
  logic signed [SW-1:0]          c;
  logic signed [OW-1:0]          pair_r;
  logic signed [OW-1:0]          opnd;
  logic signed [PW-1:0]          prod_full;
  logic [fcm_pkg::ACC_W-1:0]     prod_r;
  logic [fcm_pkg::ACC_W-1:0]     acc_r;

  // Entries never written read as zero
  always_comb begin
    x         = hist_vld ? signed'(hist_rdata) : '0;
    c         = coef_vld ? signed'(coef_rdata) : '0;
    opnd      = b_ctl_r.second ? (pair_r + OW'(x)) : OW'(x);
    prod_full = opnd * c;
  end

  // Align control with the registered RAM read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_ctl_r <= '0;
      c_vld_r <= 1'b0;
    end else begin
      b_ctl_r <= ctl;
      c_vld_r <= b_ctl_r.vld && !b_ctl_r.first;
    end
  end

  // Hold the first pair sample, register the product
  always_ff @(posedge clk) begin
    if (b_ctl_r.first) begin
      pair_r <= OW'(x);
    end
    prod_r <= prod_full[fcm_pkg::ACC_W-1:0];
  end

  // Accumulate, wrapping modulo 2^32
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc_r <= '0;
    end else if (c_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign busy = b_ctl_r.vld || c_vld_r;
  assign acc  = acc_r;

endmodule
